// ----- rtl/uiv_pkg.sv -----
// Types, constants and character-class functions shared by the UTF-8 identifier validator.
// No dependencies; every other file of the block imports this package.
package uiv_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CP_W       = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MODE = 1'd1;

  localparam logic [LEN_W-1:0] LEN_LIMIT_RST = 16'd255;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_EMPTY       = 4'd1,
    ST_TOO_LONG    = 4'd2,
    ST_BAD_UTF8    = 4'd3,
    ST_NUL         = 4'd4,
    ST_NEWLINE     = 4'd5,
    ST_TAB         = 4'd6,
    ST_CONTROL     = 4'd7,
    ST_LINE_SEP    = 4'd8,
    ST_PARA_SEP    = 4'd9,
    ST_NON_ASCII   = 4'd10,
    ST_SPACE       = 4'd11,
    ST_UNSUPPORTED = 4'd12
  } status_e;

  typedef enum logic [2:0] {
    CB_NORMAL  = 3'd0,
    CB_LOW_A0  = 3'd1,
    CB_HIGH_9F = 3'd2,
    CB_LOW_90  = 3'd3,
    CB_HIGH_8F = 3'd4
  } cont_class_e;

  function automatic status_e forbidden_code(input logic [CP_W-1:0] cp);
    status_e r;
    r = ST_OK;
    if (cp == 21'h0) begin
      r = ST_NUL;
    end else if (cp == 21'h0A || cp == 21'h0D) begin
      r = ST_NEWLINE;
    end else if (cp == 21'h09) begin
      r = ST_TAB;
    end else if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)) begin
      r = ST_CONTROL;
    end else if (cp == 21'h2028) begin
      r = ST_LINE_SEP;
    end else if (cp == 21'h2029) begin
      r = ST_PARA_SEP;
    end
    return r;
  endfunction

  function automatic status_e field_check(input logic [7:0] b);
    status_e r;
    status_e f;
    f = forbidden_code({13'd0, b});
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
        (b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == 8'h2D) begin
      r = ST_OK;
    end else if (b >= 8'h80) begin
      r = ST_NON_ASCII;
    end else if (f != ST_OK) begin
      r = f;
    end else if (b == 8'h20) begin
      r = ST_SPACE;
    end else begin
      r = ST_UNSUPPORTED;
    end
    return r;
  endfunction

endpackage

// ----- rtl/uiv_if.sv -----
// Valid/ready channel interfaces of the UTF-8 identifier validator: byte input,
// status output and configuration write. Depends on uiv_pkg.
interface uiv_in_if import uiv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface uiv_out_if import uiv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [3:0]       status;
  logic [LEN_W-1:0] name_length;

  modport source (output valid, status, name_length, input ready);
  modport sink   (input valid, status, name_length, output ready);
endinterface

interface uiv_cfg_if import uiv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/utf8_identifier_validator.sv -----
// Top level of the UTF-8 identifier validator: input register, decoder state and
// result register. Depends on uiv_pkg and the channel interfaces in uiv_if.sv.
//
// Usage: a name arrives on in_i one byte per word, last marking its final word;
// an empty name is one word with has_byte low and last high. A word with
// has_byte low and last low is dropped. Each name yields one word on out_o with
// a status code and the saturated byte count, taken from the word marked last.
// cfg_i writes the length limit (index 0) and field_mode (index 1); it is always
// ready and must only be used while no name is in flight.
// The last word of a name waits in the input register; its result is then
// registered in the result register. Throughput: one word per cycle unless a
// last word is stalled; the decoder update runs from input to state registers.
// Stall: while out_o holds an untaken result, non-last words keep flowing; a
// further last word waits in the input register and in_i.ready drops.
// Reset: the length limit returns to 255, field_mode to 0, the name state is
// cleared and both the input and result registers are emptied.
module utf8_identifier_validator import uiv_pkg::*; #(
  parameter int unsigned NAME_LIMIT = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uiv_in_if.sink     in_i,
  uiv_out_if.source  out_o,
  uiv_cfg_if.sink    cfg_i
);

  localparam logic [LEN_W-1:0] CountCap =
    LEN_W'((NAME_LIMIT < 65535) ? NAME_LIMIT : 65535);

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_has_q;
  logic             s1_last_q;

  logic [LEN_W-1:0] len_limit_q;
  logic             field_mode_q;

  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  status_e          fault_q, fault_d;
  logic [1:0]       cont_q, cont_d;
  logic [CP_W-1:0]  acc_q, acc_d;
  cont_class_e      cls_q, cls_d;

  logic             out_valid_q;
  status_e          out_status_q, status_d;
  logic [LEN_W-1:0] out_len_q;

  logic             process;
  logic [7:0]       lo, hi;
  logic [1:0]       cont_dec;
  logic [CP_W-1:0]  acc_shift;

  assign process     = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || process;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.name_length = out_len_q;

  assign cont_dec  = cont_q - 2'd1;
  assign acc_shift = {acc_q[CP_W-7:0], s1_byte_q[5:0]};

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (cls_q)
      CB_LOW_A0:  lo = 8'hA0;
      CB_HIGH_9F: hi = 8'h9F;
      CB_LOW_90:  lo = 8'h90;
      CB_HIGH_8F: hi = 8'h8F;
      default:    ;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    fault_d = fault_q;
    cont_d  = cont_q;
    acc_d   = acc_q;
    cls_d   = cls_q;
    if (s1_has_q) begin
      if (cnt_q >= CountCap) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + LEN_W'(1);
      end
      if (fault_q == ST_OK) begin
        if (field_mode_q) begin
          fault_d = field_check(s1_byte_q);
        end else if (cont_q == 2'd0) begin
          if (s1_byte_q < 8'h80) begin
            fault_d = forbidden_code({13'd0, s1_byte_q});
          end else if (s1_byte_q < 8'hC2 || s1_byte_q > 8'hF4) begin
            fault_d = ST_BAD_UTF8;
          end else if (s1_byte_q < 8'hE0) begin
            acc_d  = {16'd0, s1_byte_q[4:0]};
            cont_d = 2'd1;
            cls_d  = CB_NORMAL;
          end else if (s1_byte_q < 8'hF0) begin
            acc_d  = {17'd0, s1_byte_q[3:0]};
            cont_d = 2'd2;
            cls_d  = (s1_byte_q == 8'hE0) ? CB_LOW_A0 :
                     (s1_byte_q == 8'hED) ? CB_HIGH_9F : CB_NORMAL;
          end else begin
            acc_d  = {18'd0, s1_byte_q[2:0]};
            cont_d = 2'd3;
            cls_d  = (s1_byte_q == 8'hF0) ? CB_LOW_90 :
                     (s1_byte_q == 8'hF4) ? CB_HIGH_8F : CB_NORMAL;
          end
        end else if (s1_byte_q < lo || s1_byte_q > hi) begin
          fault_d = ST_BAD_UTF8;
        end else begin
          acc_d  = acc_shift;
          cls_d  = CB_NORMAL;
          cont_d = cont_dec;
          if (cont_dec == 2'd0) begin
            fault_d = forbidden_code(acc_shift);
          end
        end
      end
    end
  end

  always_comb begin
    priority if (cnt_d == '0 && !ovf_d) begin
      status_d = ST_EMPTY;
    end else if (ovf_d || cnt_d > len_limit_q) begin
      status_d = ST_TOO_LONG;
    end else if (fault_d != ST_OK) begin
      status_d = fault_d;
    end else if (!field_mode_q && cont_d != 2'd0) begin
      status_d = ST_BAD_UTF8;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      len_limit_q  <= LEN_LIMIT_RST;
      field_mode_q <= 1'b0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      fault_q      <= ST_OK;
      cont_q       <= 2'd0;
      acc_q        <= '0;
      cls_q        <= CB_NORMAL;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_LEN_LIMIT:  len_limit_q  <= cfg_i.data;
          CFG_FIELD_MODE: field_mode_q <= cfg_i.data[0];
          default:        ;
        endcase
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= (process && s1_last_q) || (out_valid_q && !out_o.ready);
      if (process) begin
        if (s1_last_q) begin
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
          fault_q     <= ST_OK;
          cont_q      <= 2'd0;
          acc_q       <= '0;
          cls_q       <= CB_NORMAL;
        end else begin
          cnt_q   <= cnt_d;
          ovf_q   <= ovf_d;
          fault_q <= fault_d;
          cont_q  <= cont_d;
          acc_q   <= acc_d;
          cls_q   <= cls_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_has_q  <= in_i.has_byte;
      s1_last_q <= in_i.last;
    end
    if (process && s1_last_q) begin
      out_status_q <= status_d;
      out_len_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/uiv_checker.sv -----
// Port-level checks for the UTF-8 identifier validator, bound to its top level.
// Depends on uiv_pkg and the utf8_identifier_validator ports.
module uiv_checker import uiv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [3:0]       out_status_i,
  input logic [LEN_W-1:0] out_len_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_len_i))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= ST_UNSUPPORTED)
    else $error("status code out of range");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_EMPTY |-> out_len_i == '0)
    else $error("empty name with nonzero length");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_OK |-> out_len_i != '0)
    else $error("accepted name with zero length");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a pending result");

endmodule

bind utf8_identifier_validator uiv_checker u_uiv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_len_i    (out_o.name_length)
);

// ----- tb/sv/tb_utf8_identifier_validator.sv -----
`timescale 1ns / 1ps
// Testbench for utf8_identifier_validator: feeds names as byte words, predicts each status word.
// Depends on uiv_pkg and the channel interfaces in uiv_if.sv.
module tb_utf8_identifier_validator;
  import uiv_pkg::*;

  localparam int unsigned NAME_LIMIT  = 65535;
  localparam int unsigned COUNT_CAP   = (NAME_LIMIT < 65535) ? NAME_LIMIT : 65535;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } word_t;

  typedef struct {
    status_e          status;
    logic [LEN_W-1:0] len;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uiv_in_if  in_if ();
  uiv_out_if out_if ();
  uiv_cfg_if cfg_if ();

  utf8_identifier_validator #(
    .NAME_LIMIT(NAME_LIMIT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  word_t       words[$];
  verdict_t    verdicts[$];
  logic [7:0]  name_buf[$];
  int unsigned stim_words = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  string field_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_-";
  logic [CP_W-1:0] cp_edges[0:12] = '{21'h7F, 21'h80, 21'h9F, 21'hA0, 21'h7FF, 21'h800,
    21'hD7FF, 21'hE000, 21'hFFFF, 21'h2028, 21'h2029, 21'h10000, 21'h10FFFF};

  // name checker state and its copy of the registers
  logic [LEN_W-1:0] cf_max = LEN_LIMIT_RST;
  logic             cf_field = 1'b0;
  logic [LEN_W-1:0] nm_count = '0;
  logic             nm_ovf = 1'b0;
  status_e          nm_fault = ST_OK;
  logic [1:0]       nm_cont = '0;
  logic [CP_W-1:0]  nm_cp = '0;
  cont_class_e      nm_class = CB_NORMAL;

  function automatic status_e char_code(input logic [CP_W-1:0] cp);
    if (cp == 0) return ST_NUL;
    if (cp == 21'h0A || cp == 21'h0D) return ST_NEWLINE;
    if (cp == 21'h09) return ST_TAB;
    if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)) return ST_CONTROL;
    if (cp == 21'h2028) return ST_LINE_SEP;
    if (cp == 21'h2029) return ST_PARA_SEP;
    return ST_OK;
  endfunction

  function automatic status_e field_code(input logic [7:0] b);
    status_e r;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
        b == "_" || b == "-") return ST_OK;
    if (b >= 8'h80) return ST_NON_ASCII;
    r = char_code({13'd0, b});
    if (r != ST_OK) return r;
    return (b == " ") ? ST_SPACE : ST_UNSUPPORTED;
  endfunction

  function automatic status_e decode_byte(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    status_e    r;
    lo = 8'h80;
    hi = 8'hBF;
    r  = ST_OK;
    if (nm_cont == 0) begin
      if (b < 8'h80) begin
        r = char_code({13'd0, b});
      end else if (b < 8'hC2 || b > 8'hF4) begin
        r = ST_BAD_UTF8;
      end else begin
        nm_class = CB_NORMAL;
        if (b < 8'hE0) begin
          nm_cp   = {16'd0, b[4:0]};
          nm_cont = 2'd1;
        end else if (b < 8'hF0) begin
          nm_cp   = {17'd0, b[3:0]};
          nm_cont = 2'd2;
          if (b == 8'hE0) nm_class = CB_LOW_A0;
          else if (b == 8'hED) nm_class = CB_HIGH_9F;
        end else begin
          nm_cp   = {18'd0, b[2:0]};
          nm_cont = 2'd3;
          if (b == 8'hF0) nm_class = CB_LOW_90;
          else if (b == 8'hF4) nm_class = CB_HIGH_8F;
        end
      end
    end else begin
      case (nm_class)
        CB_LOW_A0:  lo = 8'hA0;
        CB_HIGH_9F: hi = 8'h9F;
        CB_LOW_90:  lo = 8'h90;
        CB_HIGH_8F: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        r = ST_BAD_UTF8;
      end else begin
        nm_cp    = {nm_cp[14:0], b[5:0]};
        nm_class = CB_NORMAL;
        nm_cont  = nm_cont - 2'd1;
        if (nm_cont == 0) r = char_code(nm_cp);
      end
    end
    return r;
  endfunction

  task automatic judge_word(input logic [7:0] b, input logic has, input logic fin);
    status_e st;
    if (has) begin
      if (nm_count >= COUNT_CAP) nm_ovf = 1'b1;
      else nm_count = nm_count + 1'b1;
      if (nm_fault == ST_OK) nm_fault = cf_field ? field_code(b) : decode_byte(b);
    end
    if (fin) begin
      if (nm_count == 0 && !nm_ovf) st = ST_EMPTY;
      else if (nm_ovf || nm_count > cf_max) st = ST_TOO_LONG;
      else if (nm_fault != ST_OK) st = nm_fault;
      else if (!cf_field && nm_cont != 0) st = ST_BAD_UTF8;
      else st = ST_OK;
      verdicts.push_back('{st, nm_count});
      nm_count = '0;
      nm_ovf   = 1'b0;
      nm_fault = ST_OK;
      nm_cont  = '0;
      nm_cp    = '0;
      nm_class = CB_NORMAL;
    end
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : sender
    word_t w;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        judge_word(in_if.data_byte, in_if.has_byte, in_if.last);
      end
      if (in_if.valid && !in_if.ready) begin
        // hold until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (words.size() != 0) begin
        w = words.pop_front();
        {in_if.data_byte, in_if.has_byte, in_if.last} <= w;
        in_if.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall patterns plus an occasional long hold-off
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;
  int unsigned results_seen = 0;

  always @(posedge clk_i) begin : receiver
    verdict_t v;
    if (rst_ni) begin
      rx_tick++;
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (results_seen % 150 == 75) hold_left = LONG_HOLD;
        if (verdicts.size() == 0) begin
          $error("result with no name pending: status %0d, name_length %0d",
                 out_if.status, out_if.name_length);
          err_count++;
        end else begin
          v = verdicts.pop_front();
          if (out_if.status !== v.status) begin
            $error("status: expected %0d, got %0d", v.status, out_if.status);
            err_count++;
          end
          if (out_if.name_length !== v.len) begin
            $error("name_length: expected %0d, got %0d", v.len, out_if.name_length);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 120);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (rx_tick[1:0] == 2'd0);
          default: out_if.ready <= ~rx_tick[3];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    name_buf.push_back(b);
  endtask

  task automatic put_cp(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0]);
    end else if (cp < 21'h800) begin
      put({3'b110, cp[10:6]});
      put({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end else begin
      put({5'b11110, cp[20:18]});
      put({2'b10, cp[17:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
    end
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // queue the buffered name; an empty buffer gives the empty name
  task automatic emit_name(input bit tail_empty);
    int n;
    n = name_buf.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) words.push_back('{8'($urandom), 1'b0, 1'b0});
      words.push_back('{name_buf[i], 1'b1, (i == n - 1) && !tail_empty});
    end
    if (n == 0 || tail_empty) words.push_back('{8'($urandom), 1'b0, 1'b1});
    stim_words += (n == 0) ? 1 : n;
    name_buf.delete();
  endtask

  task automatic put_char();
    int unsigned     sel;
    logic [CP_W-1:0] cp;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      cp = CP_W'($urandom_range(8'h20, 8'h7E));
    end else if (sel < 62) begin
      cp = CP_W'($urandom_range(21'h80, 21'h7FF));
    end else if (sel < 74) begin
      cp = CP_W'($urandom_range(21'h800, 21'hFFFF));
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h8000;
    end else if (sel < 82) begin
      cp = cp_edges[$urandom_range(0, 12)];
    end else if (sel < 94) begin
      cp = CP_W'($urandom_range(21'h10000, 21'h10FFFF));
    end else begin
      cp = ($urandom_range(0, 7) == 0) ? 21'h7F : CP_W'($urandom_range(0, 21'h1F));
    end
    put_cp(cp);
  endtask

  task automatic put_broken();
    case ($urandom_range(0, 7))
      0: begin put(8'($urandom_range(8'hC0, 8'hC1))); put(8'($urandom_range(8'h80, 8'hBF))); end
      1: begin
        put(8'hE0); put(8'($urandom_range(8'h80, 8'h9F)));
        put(8'($urandom_range(8'h80, 8'hBF)));
      end
      2: begin
        put(8'hED); put(8'($urandom_range(8'hA0, 8'hBF)));
        put(8'($urandom_range(8'h80, 8'hBF)));
      end
      3: begin
        put(8'hF0); put(8'($urandom_range(8'h80, 8'h8F)));
        put(8'($urandom_range(8'h80, 8'hBF))); put(8'($urandom_range(8'h80, 8'hBF)));
      end
      4: begin
        put(8'hF4); put(8'($urandom_range(8'h90, 8'hBF)));
        put(8'($urandom_range(8'h80, 8'hBF))); put(8'($urandom_range(8'h80, 8'hBF)));
      end
      5: put(8'($urandom_range(8'hF5, 8'hFF)));
      6: put(8'($urandom_range(8'h80, 8'hBF)));
      default: begin
        put(8'($urandom_range(8'hC2, 8'hF4)));
        if ($urandom_range(0, 1) == 0) put(8'($urandom_range(8'h00, 8'h7F)));
        else put(8'($urandom_range(8'hC0, 8'hFF)));
      end
    endcase
  endtask

  // multi-byte character cut short
  task automatic put_truncated();
    int              start;
    int              added;
    logic [CP_W-1:0] cp;
    start = name_buf.size();
    if ($urandom_range(0, 1) == 0) cp = CP_W'($urandom_range(21'h80, 21'hD7FF));
    else cp = CP_W'($urandom_range(21'hE000, 21'h10FFFF));
    put_cp(cp);
    added = name_buf.size() - start;
    repeat ($urandom_range(1, added - 1)) void'(name_buf.pop_back());
  endtask

  task automatic gen_text_name();
    int unsigned n;
    int unsigned kind;
    int unsigned bad_at;
    n      = ($urandom_range(0, 39) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 6);
    kind   = $urandom_range(0, 9);
    bad_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      if (kind == 9) put(8'($urandom_range(0, 255)));
      else if ((kind == 6 || kind == 7) && i == bad_at) put_broken();
      else put_char();
    end
    if (kind == 8) put_truncated();
    emit_name($urandom_range(0, 7) == 0);
  endtask

  task automatic gen_field_name();
    int unsigned n;
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 88) put(field_set[$urandom_range(0, 63)]);
      else put(8'($urandom_range(0, 255)));
    end
    emit_name($urandom_range(0, 7) == 0);
  endtask

  // call right after a rising edge, with nothing in flight
  task automatic load_settings(input logic [LEN_W-1:0] mx, input logic fm);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_LEN_LIMIT;
    cfg_if.data  <= mx;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cf_max = mx;
    cfg_if.index <= CFG_FIELD_MODE;
    cfg_if.data  <= {15'($urandom), fm};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cf_field = fm;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (words.size() != 0 || in_if.valid || verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [LEN_W-1:0] mx;
    logic             fm;
    int unsigned      quota;
    int unsigned      base;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.has_byte   = 1'b0;
    in_if.last       = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_LEN_LIMIT;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: strict UTF-8, 255 bytes
    emit_name(1'b0);
    put_str("A"); emit_name(1'b0);
    words.push_back('{8'hFF, 1'b0, 1'b0});
    put_str("z"); emit_name(1'b1);
    put(8'h00); emit_name(1'b0);
    put(8'h0A); emit_name(1'b0);
    put(8'h09); emit_name(1'b0);
    put(8'h7F); emit_name(1'b0);
    put_cp(21'h2028); emit_name(1'b0);
    put_cp(21'h2029); emit_name(1'b0);
    put_cp(21'h10FFFF); emit_name(1'b0);
    put(8'hED); put(8'hA0); put(8'h80); emit_name(1'b0);
    put(8'hE2); put(8'h80); emit_name(1'b0);
    drain();

    load_settings(LEN_LIMIT_RST, 1'b1);
    put_str("_-9Z"); emit_name(1'b0);
    put_str(" "); emit_name(1'b0);
    put(8'hC3); emit_name(1'b0);
    put_str("!"); emit_name(1'b0);
    put(8'h0D); emit_name(1'b0);
    drain();

    load_settings(16'd1, 1'b0);
    put_str("ab"); emit_name(1'b0);
    put(8'h00); put(8'h00); emit_name(1'b0);
    emit_name(1'b0);
    drain();

    load_settings(16'd0, 1'b1);
    put_str("a"); emit_name(1'b0);
    emit_name(1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mx = 16'hFFFF; fm = 1'b0; end
        1: begin mx = 16'd1;    fm = 1'b1; end
        2: begin mx = 16'd0;    fm = 1'b0; end
        default: begin
          case ($urandom_range(0, 3))
            0: mx = LEN_W'($urandom_range(2, 12));
            1: mx = LEN_LIMIT_RST;
            2: mx = LEN_W'($urandom_range(0, 16'hFFFF));
            default: mx = LEN_W'($urandom_range(12, 40));
          endcase
          fm = 1'($urandom_range(0, 1));
        end
      endcase
      load_settings(mx, fm);
      quota = (mx == 0) ? 40 : 190;
      base  = stim_words;
      while (stim_words - base < quota) begin
        if (fm ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 9) == 0)) gen_field_name();
        else gen_text_name();
      end
      drain();
    end

    // length right at the limit, then one past it
    load_settings(16'd64, 1'b1);
    repeat (64) put(field_set[$urandom_range(0, 63)]);
    emit_name(1'b0);
    repeat (65) put(field_set[$urandom_range(0, 63)]);
    emit_name(1'b0);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
